### rtl/tcsp_pkg.sv
// Shared types and codes for the two-class slot pool.
package tcsp_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int CFG_AW  = 3;

    typedef enum logic [1:0] {
        OP_ACQ_ACTIVE = 2'd0,
        OP_ACQ_LISTEN = 2'd1,
        OP_RELEASE    = 2'd2,
        OP_UNUSED     = 2'd3
    } pool_op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_RSVD      = 2'd3
    } pool_status_t;

    localparam logic [CFG_AW-1:0] REG_SLOTS_IN_USE = 3'd0;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] slot_to_release;
    } pool_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic [1:0]       status;
    } pool_rsp_t;

endpackage

### rtl/two_class_slot_pool.sv
// Two-class slot pool: free-queue slot allocator with an APB register port.
// A request taken at a clock edge is held in the input register; its result, marked by
// done, is then registered in the result register.
// Throughput: one request every cycle; busy stays low, the free-queue memory has one
// write and one prefetch read of the next head entry per cycle.
// Reset, or a write of slots_in_use, returns every slot to free.
module two_class_slot_pool #(
    parameter int SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tcsp_pkg::pool_req_t         req,
    output logic                        done,
    output tcsp_pkg::pool_rsp_t         rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcsp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tcsp_pkg::*;

    localparam int POOL_LIMIT = (SLOTS < 64) ? SLOTS : 64;
    localparam int PW         = $clog2(POOL_LIMIT);
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(POOL_LIMIT);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos,
                                                input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(pos) + CNT_W'(1);
        return (nxt >= lim) ? '0 : nxt[PW-1:0];
    endfunction

    // Configuration
    logic             cfg_wr;
    logic [CNT_W-1:0] cfg_val;
    logic [CNT_W-1:0] siu_reg;

    // Input register
    logic             in_vld_reg;
    pool_req_t        in_reg;

    // Pool state
    logic [PW-1:0]         head_reg, head_next;
    logic [PW-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [POOL_LIMIT-1:0] occ_reg, occ_next;
    logic [POOL_LIMIT-1:0] wvld_reg, wvld_next;

    // Free-queue memory and head prefetch
    logic [IDX_W-1:0] free_mem [POOL_LIMIT];
    logic [IDX_W-1:0] rd_data_reg;
    logic             hit_wr_reg;
    logic             hit_byp_reg;
    logic [IDX_W-1:0] byp_data_reg;
    logic [IDX_W-1:0] head_val;

    // Result
    logic             rel_ok;
    pool_rsp_t        rsp_next, rsp_reg;
    logic             done_reg;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign prdata = (paddr[2] == REG_SLOTS_IN_USE[2]) ? {25'd0, siu_reg} : 32'd0;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE[2]);

    always_comb
    begin
        cfg_val = pwdata[CNT_W-1:0];
        if (cfg_val == '0)
            cfg_val = CNT_W'(1);
        else if (cfg_val > LIMIT_C)
            cfg_val = LIMIT_C;
    end

    // An entry never written since the last refill still holds its own position.
    assign head_val = hit_byp_reg ? byp_data_reg :
                      hit_wr_reg  ? rd_data_reg  : IDX_W'(head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        occ_next   = occ_reg;
        wvld_next  = wvld_reg;
        rel_ok     = 1'b0;
        rsp_next.slot_index = '0;
        rsp_next.status     = STATUS_NOT_FOUND;

        if (in_vld_reg)
        begin
            case (in_reg.opcode) inside
                OP_ACQ_ACTIVE, OP_ACQ_LISTEN:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        head_next  = ring_next(head_reg, siu_reg);
                        count_next = count_reg - CNT_W'(1);
                        occ_next[head_val[PW-1:0]] = 1'b1;
                        rsp_next.slot_index = head_val;
                        rsp_next.status     = STATUS_OK;
                    end
                end
                OP_RELEASE:
                begin
                    // Only the occupancy of a slot affects any result, so the
                    // active and listening classes share one occupied bit.
                    if (({1'b0, in_reg.slot_to_release} < siu_reg) &&
                        occ_reg[in_reg.slot_to_release[PW-1:0]] &&
                        (count_reg < siu_reg))
                    begin
                        rel_ok     = 1'b1;
                        occ_next[in_reg.slot_to_release[PW-1:0]] = 1'b0;
                        wvld_next[tail_reg] = 1'b1;
                        tail_next  = ring_next(tail_reg, siu_reg);
                        count_next = count_reg + CNT_W'(1);
                        rsp_next.slot_index = in_reg.slot_to_release;
                        rsp_next.status     = STATUS_OK;
                    end
                end
                default:
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
            endcase
        end

        if (cfg_wr)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = cfg_val;
            occ_next   = '0;
            wvld_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg     <= LIMIT_C;
            in_vld_reg  <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= LIMIT_C;
            occ_reg     <= '0;
            wvld_reg    <= '0;
            hit_wr_reg  <= 1'b0;
            hit_byp_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                siu_reg <= cfg_val;
            in_vld_reg <= start && !busy;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            occ_reg    <= occ_next;
            wvld_reg   <= wvld_next;
            // A release that writes the entry the head moves onto is forwarded.
            hit_byp_reg <= rel_ok && (tail_reg == head_next) && !cfg_wr;
            hit_wr_reg  <= wvld_reg[head_next] && !cfg_wr;
            done_reg    <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= req;
        byp_data_reg <= in_reg.slot_to_release;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (rel_ok)
            free_mem[tail_reg] <= in_reg.slot_to_release;
        rd_data_reg <= free_mem[head_next];
    end

endmodule

### rtl/tcsp_checker.sv
// Port-level checker for the two-class slot pool, bound to the top level.
module tcsp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input tcsp_pkg::pool_req_t         req,
    input logic                        done,
    input tcsp_pkg::pool_rsp_t         rsp
);
    import tcsp_pkg::*;

    // Every transfer yields exactly one result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request transfer without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a request transfer");

    a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != STATUS_OK)) |-> (rsp.slot_index == '0))
        else $error("failed request returned a nonzero slot index");

    a_release_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == STATUS_OK) && ($past(req.opcode, 2) == OP_RELEASE))
        |-> (rsp.slot_index == $past(req.slot_to_release, 2)))
        else $error("successful release returned a different slot");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status != STATUS_RSVD))
        else $error("reserved status code on a result");

endmodule

bind two_class_slot_pool tcsp_checker u_tcsp_checker (.*);
